// File: rtl/fti_pkg.sv
`default_nettype none

package fti_pkg;

	localparam int NUM_POINTS     = 11;
	localparam int NUM_SEGS       = NUM_POINTS - 1;
	localparam int DB_FRAC_BITS   = 8;
	localparam int NORM_FRAC_BITS = 15;
	localparam int TABLE_SLOTS    = 16;

	localparam int VAL_W     = 17;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SEG_W     = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;

	localparam int PIPE_DEPTH = 5;

	localparam int FULL_TRAVEL = 1 << NORM_FRAC_BITS;

	localparam int RST_SILENCE_DB   = -25600;
	localparam int RST_MIN_DB       = -16640;
	localparam int RST_MAX_DB       = 3072;
	localparam int RST_SILENCE_NORM = 0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SILENCE_DB   = 2'd0,
		REG_MIN_DB       = 2'd1,
		REG_MAX_DB       = 2'd2,
		REG_SILENCE_NORM = 2'd3
	} reg_idx_t;

	// breakpoints: whole dB and hundredths of travel
	localparam int DB_WHOLE [TABLE_SLOTS] = '{
		-65, -50, -40, -30, -20, -12, -6, 0, 6, 12, 12, 12, 12, 12, 12, 12
	};
	localparam int NORM_HUND [TABLE_SLOTS] = '{
		2, 9, 18, 28, 40, 53, 66, 80, 92, 100, 100, 100, 100, 100, 100, 100
	};

	function automatic int pt_db(int i);
		return DB_WHOLE[i] * (1 << DB_FRAC_BITS);
	endfunction

	function automatic int pt_norm(int i);
		return (NORM_HUND[i] * (1 << NORM_FRAC_BITS) + 50) / 100;
	endfunction

	// action 0 maps dB to position, action 1 position to dB
	function automatic int pt_in(int act, int i);
		return (act != 0) ? pt_norm(i) : pt_db(i);
	endfunction

	function automatic int pt_out(int act, int i);
		return (act != 0) ? pt_db(i) : pt_norm(i);
	endfunction

	function automatic int max_span();
		int m;
		m = 1;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_SEGS; i++) begin
				if (pt_in(a, i + 1) - pt_in(a, i) > m) begin
					m = pt_in(a, i + 1) - pt_in(a, i);
				end
				if (pt_out(a, i + 1) - pt_out(a, i) > m) begin
					m = pt_out(a, i + 1) - pt_out(a, i);
				end
			end
		end
		return m;
	endfunction

	localparam int SPAN_W = $clog2(max_span() + 1);
	localparam int N_W    = 2 * SPAN_W + 1;
	localparam int RSH    = N_W;
	localparam int R_W    = RSH + 1;

	typedef logic [1:0][NUM_POINTS-1:0][VAL_W-1:0] pt_tab_t;
	typedef logic [1:0][NUM_SEGS-1:0][SPAN_W-1:0]  span_tab_t;
	typedef logic [1:0][NUM_SEGS-1:0][R_W-1:0]     recip_tab_t;

	// floor(2^RSH / den) by shift and subtract
	function automatic logic [R_W-1:0] recip(int den);
		longint r;
		logic [R_W-1:0] q;
		q = '0;
		r = 0;
		if (den > 0) begin
			for (int b = RSH; b >= 0; b--) begin
				r = r * 2 + ((b == RSH) ? 1 : 0);
				if (r >= den) begin
					r = r - den;
					q[b] = 1'b1;
				end
			end
		end
		return q;
	endfunction

	function automatic pt_tab_t build_in_pt();
		pt_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				t[a][i] = VAL_W'(pt_in(a, i));
			end
		end
		return t;
	endfunction

	function automatic pt_tab_t build_out_pt();
		pt_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_POINTS; i++) begin
				t[a][i] = VAL_W'(pt_out(a, i));
			end
		end
		return t;
	endfunction

	function automatic span_tab_t build_den();
		span_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_SEGS; i++) begin
				t[a][i] = SPAN_W'(pt_in(a, i + 1) - pt_in(a, i));
			end
		end
		return t;
	endfunction

	function automatic span_tab_t build_half();
		span_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_SEGS; i++) begin
				t[a][i] = SPAN_W'((pt_in(a, i + 1) - pt_in(a, i)) >> 1);
			end
		end
		return t;
	endfunction

	function automatic span_tab_t build_dy();
		span_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_SEGS; i++) begin
				t[a][i] = SPAN_W'(pt_out(a, i + 1) - pt_out(a, i));
			end
		end
		return t;
	endfunction

	function automatic recip_tab_t build_recip();
		recip_tab_t t;
		for (int a = 0; a < 2; a++) begin
			for (int i = 0; i < NUM_SEGS; i++) begin
				t[a][i] = recip(pt_in(a, i + 1) - pt_in(a, i));
			end
		end
		return t;
	endfunction

	localparam pt_tab_t    IN_PT     = build_in_pt();
	localparam pt_tab_t    OUT_PT    = build_out_pt();
	localparam span_tab_t  DEN_TAB   = build_den();
	localparam span_tab_t  HALF_TAB  = build_half();
	localparam span_tab_t  DY_TAB    = build_dy();
	localparam recip_tab_t RECIP_TAB = build_recip();

	typedef struct packed {
		logic [CFG_W-1:0] silence_db;
		logic [CFG_W-1:0] min_db;
		logic [CFG_W-1:0] max_db;
		logic [CFG_W-1:0] silence_norm;
	} cfg_t;

	typedef struct packed {
		logic             action;
		logic             silent;
		logic             use_const;
		logic [VAL_W-1:0] const_val;
		logic [SEG_W-1:0] seg;
	} ctl_t;

	typedef struct packed {
		ctl_t              ctl;
		logic [SPAN_W-1:0] dx;
	} loc_t;

endpackage

`default_nettype wire

// File: rtl/fti_locate.sv
`default_nettype none

module fti_locate
	import fti_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         valid_s1,
	input  wire logic                    down_ready,
	output loc_t                         loc_s1
);

	localparam logic signed [VAL_W-1:0] FULL_V = VAL_W'(FULL_TRAVEL);

	logic signed [VAL_W-1:0] sdb;
	logic signed [VAL_W-1:0] mindb;
	logic signed [VAL_W-1:0] maxdb;
	logic signed [VAL_W-1:0] snorm;
	logic signed [VAL_W-1:0] pn0;
	logic signed [VAL_W-1:0] lo_i;
	logic signed [VAL_W-1:0] hi_i;
	logic signed [VAL_W-1:0] lo_sel;
	logic signed [VAL_W-1:0] hi_sel;
	logic signed [VAL_W:0]   diff;
	logic                    found;
	logic [SEG_W-1:0]        seg_sel;
	logic                    low;
	logic                    high;
	logic [VAL_W-1:0]        low_val;
	logic [VAL_W-1:0]        high_val;
	loc_t                    loc_d;

	assign sdb   = {{(VAL_W-CFG_W){cfg.silence_db[CFG_W-1]}}, cfg.silence_db};
	assign mindb = {{(VAL_W-CFG_W){cfg.min_db[CFG_W-1]}}, cfg.min_db};
	assign maxdb = {{(VAL_W-CFG_W){cfg.max_db[CFG_W-1]}}, cfg.max_db};
	assign snorm = {{(VAL_W-CFG_W){1'b0}}, cfg.silence_norm};
	assign pn0   = IN_PT[1][0];

	// first segment holding the value
	always_comb begin
		found   = 1'b0;
		seg_sel = '0;
		lo_i    = '0;
		hi_i    = '0;
		for (int i = 0; i < NUM_SEGS; i++) begin
			lo_i = IN_PT[action][i];
			hi_i = IN_PT[action][i+1];
			if (!found && value >= lo_i && value <= hi_i) begin
				found   = 1'b1;
				seg_sel = SEG_W'(i);
			end
		end
	end

	always_comb begin
		lo_sel = IN_PT[action][seg_sel];
		hi_sel = IN_PT[action][SEG_W'(seg_sel + 1'b1)];
		diff   = {value[VAL_W-1], value} - {lo_sel[VAL_W-1], lo_sel};
		if (!action) begin
			low      = (value <= sdb) || (value < mindb);
			high     = !low && (value >= maxdb);
			low_val  = snorm;
			high_val = FULL_V;
		end else begin
			low      = (value <= snorm) || (value < FULL_V && value < pn0);
			high     = !(value <= snorm) && (value >= FULL_V);
			low_val  = sdb;
			high_val = maxdb;
		end

		loc_d.ctl.action = action;
		loc_d.ctl.silent = !action && (value <= mindb);
		loc_d.ctl.seg    = seg_sel;
		loc_d.dx         = diff[SPAN_W-1:0];
		if (low) begin
			loc_d.ctl.use_const = 1'b1;
			loc_d.ctl.const_val = low_val;
		end else if (high || !found) begin
			loc_d.ctl.use_const = 1'b1;
			loc_d.ctl.const_val = high_val;
		end else if (lo_sel == hi_sel) begin
			loc_d.ctl.use_const = 1'b1;
			loc_d.ctl.const_val = OUT_PT[action][SEG_W'(seg_sel + 1'b1)];
		end else begin
			loc_d.ctl.use_const = 1'b0;
			loc_d.ctl.const_val = low_val;
		end
	end

	assign in_ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			loc_s1 <= loc_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/fti_interp.sv
`default_nettype none

module fti_interp
	import fti_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s1,
	output logic                  ready_s2,
	input  wire loc_t             loc_s1,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic signed [VAL_W-1:0] result,
	output logic                  silent
);

	logic valid_s2, valid_s3, valid_s4, valid_s5;
	logic ready_s3, ready_s4, ready_s5;

	ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [N_W-1:0]    n_s2, n_s3;
	logic [SPAN_W-1:0] q_s3, q_s4;
	logic              fix_s4;
	logic [VAL_W-1:0]  result_s5;
	logic              silent_s5;

	logic [N_W-1:0]     dx_e, dy_e, half_e, n_d;
	logic [N_W+R_W-1:0] prod;
	logic [N_W-1:0]     qd, rem, den_e;
	logic [VAL_W-1:0]   out_lo, res_d;

	assign ready_s5 = !valid_s5 || out_ready;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;

	// numerator: offset times output span plus half a denominator
	always_comb begin
		dx_e   = N_W'(loc_s1.dx);
		dy_e   = N_W'(DY_TAB[loc_s1.ctl.action][loc_s1.ctl.seg]);
		half_e = N_W'(HALF_TAB[loc_s1.ctl.action][loc_s1.ctl.seg]);
		n_d    = N_W'(dx_e * dy_e) + half_e;
	end

	// quotient estimate, low by at most one
	always_comb begin
		prod = (N_W+R_W)'(n_s2) * (N_W+R_W)'(RECIP_TAB[ctl_s2.action][ctl_s2.seg]);
	end

	always_comb begin
		den_e = N_W'(DEN_TAB[ctl_s3.action][ctl_s3.seg]);
		qd    = N_W'(N_W'(q_s3) * den_e);
		rem   = n_s3 - qd;
	end

	always_comb begin
		out_lo = OUT_PT[ctl_s4.action][ctl_s4.seg];
		if (ctl_s4.use_const) begin
			res_d = ctl_s4.const_val;
		end else begin
			res_d = out_lo + VAL_W'(q_s4) + VAL_W'(fix_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			ctl_s2 <= loc_s1.ctl;
			n_s2   <= n_d;
		end
		if (ready_s3 && valid_s2) begin
			ctl_s3 <= ctl_s2;
			n_s3   <= n_s2;
			q_s3   <= prod[RSH +: SPAN_W];
		end
		if (ready_s4 && valid_s3) begin
			ctl_s4 <= ctl_s3;
			q_s4   <= q_s3;
			fix_s4 <= (rem >= den_e);
		end
		if (ready_s5 && valid_s4) begin
			result_s5 <= res_d;
			silent_s5 <= ctl_s4.silent;
		end
	end

	assign out_valid = valid_s5;
	assign result    = result_s5;
	assign silent    = silent_s5;

endmodule

`default_nettype wire

// File: rtl/fader_taper_interpolator.sv
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    action, value
// out      output     out_valid / out_ready  result, silent
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle in and out while out_ready is high; one register stage each for
// segment search, product, reciprocal multiply, remainder check and final add
// reset restores the four threshold registers and clears every stage valid
// a stalled output holds its stage; earlier stages keep filling until all are full
// cfg_ready is always high
`default_nettype none

module fader_taper_interpolator
	import fti_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    action,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [VAL_W-1:0]      result,
	output logic                         silent,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data
);

	localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic             ready_s2;
	loc_t             loc_s1;
	logic [OCC_W-1:0] occ_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.silence_db   <= CFG_W'(RST_SILENCE_DB);
			cfg_q.min_db       <= CFG_W'(RST_MIN_DB);
			cfg_q.max_db       <= CFG_W'(RST_MAX_DB);
			cfg_q.silence_norm <= CFG_W'(RST_SILENCE_NORM);
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_SILENCE_DB:   cfg_q.silence_db   <= cfg_data;
				REG_MIN_DB:       cfg_q.min_db       <= cfg_data;
				REG_MAX_DB:       cfg_q.max_db       <= cfg_data;
				REG_SILENCE_NORM: cfg_q.silence_norm <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fti_locate u_locate (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.valid_s1   (valid_s1),
		.down_ready (ready_s2),
		.loc_s1     (loc_s1)
	);

	fti_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ready_s2  (ready_s2),
		.loc_s1    (loc_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result),
		.silent    (silent)
	);

	// transactions in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(PIPE_DEPTH))
		else $error("more transactions in flight than stages");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready && occ_q == OCC_W'(PIPE_DEPTH))
		else $error("input refused while pipeline has room");

	a_out_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result shown with nothing in flight");

endmodule

`default_nettype wire
